// ----- hw/rtl/hsfr_pkg.sv -----
package hsfr_pkg;

  localparam int unsigned MaxSensorsDef = 8;
  localparam int unsigned OutValues     = 8;
  localparam int unsigned ValueW        = 16;
  localparam int unsigned CountW        = 4;
  localparam int unsigned DigitCntW     = 6;
  localparam int unsigned LimitW        = 4;
  localparam int unsigned DataW         = 32;
  localparam int unsigned AddrW         = 3;

  localparam logic [7:0] CharHash   = 8'h23;  // '#'
  localparam logic [7:0] CharDollar = 8'h24;  // '$'
  localparam logic [7:0] Char0      = 8'h30;
  localparam logic [7:0] Char9      = 8'h39;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpF    = 8'h46;
  localparam logic [7:0] CharLoA    = 8'h61;
  localparam logic [7:0] CharLoF    = 8'h66;

  localparam logic [LimitW-1:0] ErrorLimitRst = 4'd5;

  // register index of error_limit
  localparam logic RegErrorLimit = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ODD       = 2'd1,
    STAT_BAD_COUNT = 2'd2,
    STAT_SYNC_LOST = 2'd3
  } status_e;

  typedef struct packed {
    logic                             valid;
    status_e                          status;
    logic [CountW-1:0]                count;
    logic [OutValues-1:0][ValueW-1:0] values;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } nibble_t;

  function automatic nibble_t hex_nibble(logic [7:0] c);
    nibble_t r;
    r = '0;
    if (c >= Char0 && c <= Char9) begin
      r.ok  = 1'b1;
      r.nib = 4'(c - Char0);
    end else if (c >= CharUpA && c <= CharUpF) begin
      r.ok  = 1'b1;
      r.nib = 4'(c - CharUpA + 8'd10);
    end else if (c >= CharLoA && c <= CharLoF) begin
      r.ok  = 1'b1;
      r.nib = 4'(c - CharLoA + 8'd10);
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/hex_sensor_frame_receiver_top.sv -----
// Flow: an accepted word is held in the input register and decoded from there;
//   the decode step writes its result, if any, into the output register, and it
//   waits only while an earlier result sits in the output register untaken.
// Throughput: one word per cycle; the input register refills in the same cycle
//   the decode step drains it, limited only by the output register being taken.
// Reset: rst_ni is asynchronous, active low; clears sync, frame and error state
//   and sets error_limit to 5. Sensor value registers are not reset.
module hex_sensor_frame_receiver_top import hsfr_pkg::*; #(
  parameter int unsigned MAX_SENSORS = MaxSensorsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [3:0]         sensor_count_o,
  output logic [15:0]        value0_o,
  output logic [15:0]        value1_o,
  output logic [15:0]        value2_o,
  output logic [15:0]        value3_o,
  output logic [15:0]        value4_o,
  output logic [15:0]        value5_o,
  output logic [15:0]        value6_o,
  output logic [15:0]        value7_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  logic              in_vld_q;
  logic [7:0]        byte_q;
  logic              step;
  logic [LimitW-1:0] error_limit;
  result_t           res;
  result_t           out_q;
  logic              out_vld_q;

  hsfr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .error_limit_o(error_limit)
  );

  // decode fires when the held word has somewhere to put a result
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  hsfr_frame #(
    .MAX_SENSORS(MAX_SENSORS)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (byte_q),
    .error_limit_i(error_limit),
    .res_o        (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && res.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_q.status;
  assign sensor_count_o = out_q.count;
  assign value0_o       = out_q.values[0];
  assign value1_o       = out_q.values[1];
  assign value2_o       = out_q.values[2];
  assign value3_o       = out_q.values[3];
  assign value4_o       = out_q.values[4];
  assign value5_o       = out_q.values[5];
  assign value6_o       = out_q.values[6];
  assign value7_o       = out_q.values[7];

endmodule

// ----- hw/rtl/hsfr_cfg.sv -----
module hsfr_cfg import hsfr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [DataW-1:0]        pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready,
  output logic [LimitW-1:0]       error_limit_o
);

  logic [LimitW-1:0] limit_q, limit_d;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegErrorLimit);

  always_comb begin
    limit_d = limit_q;
    if (wr_en) begin
      limit_d = pwdata[LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ErrorLimitRst;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegErrorLimit) begin
      prdata = DataW'(limit_q);
    end
  end

  assign error_limit_o = limit_q;

endmodule

// ----- hw/rtl/hsfr_frame.sv -----
module hsfr_frame import hsfr_pkg::*; #(
  parameter int unsigned MAX_SENSORS = MaxSensorsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [LimitW-1:0] error_limit_i,
  output result_t           res_o
);

  localparam logic [DigitCntW:0] MaxDigits = (DigitCntW+1)'(4 * MAX_SENSORS);
  localparam int unsigned NOut = (MAX_SENSORS < OutValues) ? MAX_SENSORS : OutValues;

  logic                 synced_q, synced_d;
  logic                 in_frame_q, in_frame_d;
  logic                 ovf_q, ovf_d;
  logic [DigitCntW-1:0] dcnt_q, dcnt_d;
  logic [LimitW-1:0]    bad_q, bad_d;
  logic [ValueW-1:0]    vals_q [MAX_SENSORS];
  logic [ValueW-1:0]    vals_d [MAX_SENSORS];

  nibble_t           hx;
  logic              bad_byte;
  logic [LimitW-1:0] bad_inc;
  logic [CountW-1:0] cnt;
  result_t           res;

  assign hx      = hex_nibble(byte_i);
  assign bad_inc = bad_q + 1'b1;
  assign cnt     = dcnt_q[DigitCntW-1:2];

  always_comb begin
    synced_d   = synced_q;
    in_frame_d = in_frame_q;
    ovf_d      = ovf_q;
    dcnt_d     = dcnt_q;
    bad_d      = bad_q;
    vals_d     = vals_q;
    bad_byte   = 1'b0;
    res        = '0;

    if (!synced_q) begin
      // hunting: only an end mark matters
      if (byte_i == CharDollar) begin
        synced_d   = 1'b1;
        in_frame_d = 1'b0;
      end
    end else if (byte_i == CharHash) begin
      in_frame_d = 1'b1;
      ovf_d      = 1'b0;
      dcnt_d     = '0;
      vals_d     = '{default: '0};
    end else if (!in_frame_q) begin
      bad_byte = 1'b1;
    end else if (byte_i == CharDollar) begin
      in_frame_d = 1'b0;
      res.valid  = 1'b1;
      if (ovf_q) begin
        res.status = STAT_BAD_COUNT;
      end else if (dcnt_q[0]) begin
        res.status = STAT_ODD;
      end else if (cnt == '0 || cnt > CountW'(OutValues)) begin
        res.status = STAT_BAD_COUNT;
      end else begin
        res.status = STAT_OK;
        res.count  = cnt;
        for (int k = 0; k < NOut; k++) begin
          if (CountW'(k) < cnt) begin
            res.values[k] = vals_q[k];
          end
        end
      end
    end else if (!hx.ok) begin
      in_frame_d = 1'b0;
      bad_byte   = 1'b1;
    end else if ({1'b0, dcnt_q} >= MaxDigits || dcnt_q == '1) begin
      ovf_d = 1'b1;
    end else begin
      for (int s = 0; s < MAX_SENSORS; s++) begin
        if (dcnt_q[DigitCntW-1:2] == CountW'(s)) begin
          vals_d[s] = {vals_q[s][ValueW-5:0], hx.nib};
        end
      end
      dcnt_d = dcnt_q + 1'b1;
    end

    if (bad_byte) begin
      if (bad_inc >= error_limit_i) begin
        synced_d   = 1'b0;
        in_frame_d = 1'b0;
        bad_d      = '0;
        res.valid  = 1'b1;
        res.status = STAT_SYNC_LOST;
      end else begin
        bad_d = bad_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q   <= 1'b0;
      in_frame_q <= 1'b0;
      ovf_q      <= 1'b0;
      dcnt_q     <= '0;
      bad_q      <= '0;
    end else if (step_i) begin
      synced_q   <= synced_d;
      in_frame_q <= in_frame_d;
      ovf_q      <= ovf_d;
      dcnt_q     <= dcnt_d;
      bad_q      <= bad_d;
    end
  end

  // values are only read after a '#' has cleared them
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      vals_q <= vals_d;
    end
  end

  assign res_o = res;

  a_hunt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !synced_q |-> !res.valid)
    else $error("result while hunting for sync");

  a_sync_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.valid && res.status == STAT_SYNC_LOST |=> !synced_q && bad_q == '0)
    else $error("sync loss did not clear state");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.status != STAT_OK |-> res.count == '0 && res.values == '0)
    else $error("error result carries data");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.status == STAT_OK |-> res.count != '0 && res.count <= CountW'(OutValues))
    else $error("valid frame count out of range");

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import hsfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned ItemsPerPhase = 90;
  // leave some slack before touching config
  localparam int unsigned SettleCycles  = 6;
  // slowest run stays well below this limit (long gaps plus long stalls per word)
  localparam int unsigned CycleLimit    = 400_000;
  localparam int unsigned MaxDigits     = 4 * MaxSensorsDef;
  localparam int unsigned MaxReported   = 10;
  localparam logic [AddrW-1:0] LimitAddr = AddrW'(4 * RegErrorLimit);

  // one decoded frame report as the block should present it
  typedef struct {
    status_e                          status;
    logic [CountW-1:0]                count;
    logic [OutValues-1:0][ValueW-1:0] vals;
  } frame_report_t;

  // ---------------------------------------------------------------------------
  // clock, reset and DUT connections
  // ---------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic [3:0]        sensor_count;
  logic [15:0]       value0, value1, value2, value3, value4, value5, value6, value7;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  always #(ClkPeriod / 2) clk = ~clk;

  hex_sensor_frame_receiver_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .sensor_count_o (sensor_count),
    .value0_o       (value0),
    .value1_o       (value1),
    .value2_o       (value2),
    .value3_o       (value3),
    .value4_o       (value4),
    .value5_o       (value5),
    .value6_o       (value6),
    .value7_o       (value7),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  logic [7:0]    pending_bytes [$];     // words waiting for the driver
  frame_report_t frame_reports_due [$]; // predicted reports, oldest first
  int unsigned   bytes_queued  = 0;
  int unsigned   mismatches    = 0;
  int unsigned   cycle_count   = 0;
  int unsigned   status_seen [4] = '{0, 0, 0, 0};
  int unsigned   limits_tried  = 1;     // reset value counts as the first

  // ---------------------------------------------------------------------------
  // frame decoder prediction: own copy of sync/frame state and error_limit
  // ---------------------------------------------------------------------------
  logic                             in_sync        = 1'b0;
  logic                             frame_open     = 1'b0;
  logic                             frame_overflow = 1'b0;
  logic [DigitCntW-1:0]             digits_seen    = '0;
  logic [LimitW-1:0]                bad_bytes      = '0;
  logic [OutValues-1:0][ValueW-1:0] frame_values   = '0;
  logic [LimitW-1:0]                error_limit_cfg = ErrorLimitRst;

  // '0'..'9' and letters a..f in either case; bit 5 folds upper onto lower
  function automatic bit decode_hex(input logic [7:0] c, output logic [3:0] nib);
    nib = '0;
    if (c >= Char0 && c <= Char9) begin
      nib = c[3:0];
      return 1'b1;
    end
    if ((c | 8'h20) >= CharLoA && (c | 8'h20) <= CharLoF) begin
      nib = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // error counter is 4 bits; reaching the limit drops sync
  function automatic bit bad_byte_drops_sync();
    bad_bytes = bad_bytes + 4'd1;
    if (bad_bytes >= error_limit_cfg) begin
      in_sync    = 1'b0;
      frame_open = 1'b0;
      bad_bytes  = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic decode_byte(input logic [7:0] c);
    frame_report_t     rpt;
    logic [3:0]        nib;
    logic [CountW-1:0] groups;
    bit                report;
    int                k;
    rpt.status = STAT_OK;
    rpt.count  = '0;
    rpt.vals   = '0;
    report     = 1'b0;
    groups     = CountW'(digits_seen >> 2);
    if (!in_sync) begin
      // hunting: only an end mark counts, and it just re-syncs
      if (c == CharDollar) begin
        in_sync    = 1'b1;
        frame_open = 1'b0;
      end
    end else if (c == CharHash) begin
      // start mark opens a frame, also on top of an open one
      frame_open     = 1'b1;
      frame_overflow = 1'b0;
      digits_seen    = '0;
      frame_values   = '0;
    end else if (!frame_open) begin
      report     = bad_byte_drops_sync();
      rpt.status = STAT_SYNC_LOST;
    end else if (c == CharDollar) begin
      frame_open = 1'b0;
      report     = 1'b1;
      if (frame_overflow) begin
        rpt.status = STAT_BAD_COUNT;
      end else if (digits_seen[0]) begin
        rpt.status = STAT_ODD;
      end else if (groups == 0 || groups > OutValues) begin
        rpt.status = STAT_BAD_COUNT;
      end else begin
        rpt.count = groups;
        for (k = 0; k < OutValues; k++) begin
          if (k < groups) rpt.vals[k] = frame_values[k];
        end
      end
    end else if (!decode_hex(c, nib)) begin
      frame_open = 1'b0;
      report     = bad_byte_drops_sync();
      rpt.status = STAT_SYNC_LOST;
    end else if (digits_seen >= MaxDigits) begin
      frame_overflow = 1'b1;
    end else begin
      // most significant digit first
      frame_values[digits_seen >> 2] = {frame_values[digits_seen >> 2][11:0], nib};
      digits_seen = digits_seen + 1'b1;
    end
    if (report) frame_reports_due.push_back(rpt);
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // idling: mostly short gaps, now and then a long one; calm stretches have none
  // ---------------------------------------------------------------------------
  function automatic int unsigned pause_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // byte driver: pops the next word at the falling edge once the last one went
  // ---------------------------------------------------------------------------
  logic        byte_taken = 1'b0;
  int unsigned gap_left   = 0;
  bit          send_calm  = 1'b0;

  always @(negedge clk) begin
    if (!in_valid || byte_taken) begin
      if (byte_taken) begin
        if ($urandom_range(0, 63) == 0) send_calm = ~send_calm;
        gap_left = send_calm ? 0 : pause_length();
      end
      if (gap_left > 0 || pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid <= 1'b1;
        rx_byte  <= pending_bytes.pop_front();
      end
    end
  end

  // result side back-pressure
  int unsigned stall_left = 0;
  bit          take_calm  = 1'b0;

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) take_calm = ~take_calm;
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = take_calm ? 0 : pause_length();
      out_ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted word, check every accepted report
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_report_t                    want;
    logic [OutValues-1:0][ValueW-1:0] got_vals;
    int                               k;
    byte_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) decode_byte(rx_byte);
      if (out_valid && out_ready) begin
        got_vals = {value7, value6, value5, value4, value3, value2, value1, value0};
        if (frame_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("%0t: report with none pending, status %0d count %0d",
                     $realtime, status, sensor_count);
        end else begin
          want = frame_reports_due.pop_front();
          status_seen[want.status]++;
          check_field("status", want.status, status);
          check_field("sensor_count", want.count, sensor_count);
          for (k = 0; k < OutValues; k++)
            check_field($sformatf("value%0d", k), want.vals[k], got_vals[k]);
        end
      end
    end
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL hex_sensor_frame_receiver_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // configuration port: setup cycle then access cycle, pready always high
  // ---------------------------------------------------------------------------
  task automatic apb_cycle(input bit wr, input logic [DataW-1:0] wdata,
                           output logic [DataW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LimitAddr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write error_limit, let the prediction follow, then read it back
  task automatic write_error_limit(input logic [LimitW-1:0] limit);
    logic [DataW-1:0] rd;
    apb_cycle(1'b1, DataW'(limit), rd);
    error_limit_cfg = limit;
    apb_cycle(1'b0, '0, rd);
    check_field("error_limit readback", limit, rd[LimitW-1:0]);
    limits_tried++;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] random_digit();
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    if (n < 10) return Char0 + 8'(n);
    return ($urandom_range(0, 1) ? CharLoA : CharUpA) + 8'(n) - 8'd10;
  endfunction

  // any byte that is neither a digit nor a frame mark
  function automatic logic [7:0] random_junk();
    logic [7:0] c;
    logic [3:0] nib;
    do c = 8'($urandom_range(0, 255));
    while (decode_hex(c, nib) || c == CharHash || c == CharDollar);
    return c;
  endfunction

  task automatic queue_frame(input int unsigned n_digits);
    queue_byte(CharHash);
    repeat (n_digits) queue_byte(random_digit());
    queue_byte(CharDollar);
  endtask

  // half well-formed frames with random digits, the rest broken or noise
  task automatic queue_random_event();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      // small frames dominate, full eight-value frames now and then
      if ($urandom_range(0, 9) < 7) queue_frame(4 * $urandom_range(1, 3));
      else queue_frame(4 * $urandom_range(4, 8));
    end else if (r < 58) begin
      queue_frame(2 * $urandom_range(0, 16) + 1);     // odd digit count
    end else if (r < 63) begin
      queue_frame(2 * $urandom_range(0, 1));          // no full value
    end else if (r < 67) begin
      queue_frame($urandom_range(MaxDigits + 1, MaxDigits + 8));  // overflow
    end else if (r < 74) begin
      // abandoned frame, restarted by a new start mark
      queue_byte(CharHash);
      repeat ($urandom_range(0, 9)) queue_byte(random_digit());
      queue_frame(4 * $urandom_range(1, 4));
    end else if (r < 82) begin
      // junk in the middle of a frame
      queue_byte(CharHash);
      repeat ($urandom_range(0, 8)) queue_byte(random_digit());
      queue_byte(random_junk());
    end else if (r < 95) begin
      // raw line noise; long bursts push the error count to high limits
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(10, 16)) queue_byte(8'($urandom_range(0, 255)));
      else
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
    end else begin
      queue_byte(CharDollar);                         // stray end mark
    end
  endtask

  // wait for every word to go in and every report to come out, then settle
  task automatic drain_and_settle();
    while (pending_bytes.size() != 0 || in_valid || frame_reports_due.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    logic [7:0]        opening_bytes [$];
    logic [LimitW-1:0] limit_plan [7];
    int unsigned       stop_at;

    // extremes first: 1 and 15, and zero, which behaves like 1
    limit_plan = '{4'd1, 4'd15, 4'd0, 4'($urandom_range(2, 14)),
                   4'($urandom_range(2, 14)), 4'($urandom_range(2, 14)), 4'd9};

    opening_bytes = '{
      8'h00, 8'hFF, CharHash,                       // dropped while hunting
      CharDollar,                                   // end mark syncs
      "z",                                          // bad byte outside a frame
      CharHash, "f", "F", "0", "9", CharDollar,     // one value, mixed case
      CharHash, "7", CharDollar,                    // odd digit count
      CharHash, CharDollar,                         // empty frame
      CharHash, "1", CharHash, "A", "b", "c", "d", CharDollar,  // restart
      CharHash, "G"                                 // junk inside a frame
    };

    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;

    // directed part runs at the reset limit of 5
    foreach (opening_bytes[i]) queue_byte(opening_bytes[i]);
    drain_and_settle();

    foreach (limit_plan[i]) begin
      write_error_limit(limit_plan[i]);
      stop_at = bytes_queued + ItemsPerPhase;
      while (bytes_queued < stop_at) queue_random_event();
      drain_and_settle();
    end

    $display("Ran %0d bytes under %0d error-limit settings, including 0, 1 and 15.",
             bytes_queued, limits_tried);
    $display("Reports checked: %0d valid, %0d odd count, %0d bad count, %0d sync lost.",
             status_seen[STAT_OK], status_seen[STAT_ODD], status_seen[STAT_BAD_COUNT],
             status_seen[STAT_SYNC_LOST]);
    if (mismatches == 0 && frame_reports_due.size() == 0) begin
      $display("PASS hex_sensor_frame_receiver_top");
    end else begin
      $display("FAIL hex_sensor_frame_receiver_top");
    end
    $finish;
  end

endmodule

// ----- hex_sensor_frame_receiver_top.f -----
hw/rtl/hsfr_pkg.sv
hw/rtl/hsfr_cfg.sv
hw/rtl/hsfr_frame.sv
hw/rtl/hex_sensor_frame_receiver_top.sv
dv/testbench.sv
